// File: hw/rtl/rsi_pkg.sv
// shared widths, constants and the front-to-back item type of the ray-sphere intersection block
// no dependencies
package rsi_pkg;

  // default fraction bits of the fixed-point fields
  localparam int unsigned FRAC_BITS_DEF = 16;

  // widths of the quadratic terms
  localparam int unsigned HBW = 67;   // half_b, signed
  localparam int unsigned AW  = 64;   // a = d.d, unsigned
  localparam int unsigned DW  = 132;  // discriminant, signed, even for the root recurrence
  localparam int unsigned RTW = DW / 2;   // integer square root
  localparam int unsigned RMW = RTW + 4;  // root remainder
  localparam int unsigned QB  = 33;   // quotient bits kept before saturation

  // one classified test handed from the front end to the back end
  typedef struct packed {
    logic                  hit;
    logic signed [HBW-1:0] hb;
    logic [AW-1:0]         a;
    logic [DW-1:0]         disc;
  } rsi_item_t;

endpackage

// File: hw/rtl/rsi_if.sv
// channel interfaces for the ray-sphere intersection block
// no dependencies
interface rsi_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [30:0]        sphere_radius;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;

  modport source(output valid, center_x, center_y, center_z, sphere_radius,
                 origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, input ready);
  modport sink(input valid, center_x, center_y, center_z, sphere_radius,
               origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, output ready);
endinterface

interface rsi_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] distance;

  modport source(output valid, hit, distance, input ready);
  modport sink(input valid, hit, distance, output ready);
endinterface

// File: hw/rtl/ray_sphere_intersection_top.sv
// Ray-sphere intersection test in fixed point. Takes one sphere and one ray per beat and
// returns hit and the nearer root distance; a miss or a zero direction gives hit 0 and -1.0.
// Fully pipelined: one beat per cycle sustained while out_bus is ready. A beat passes 8 front stages,
// the two-entry queue and RTW + QB + 3 = 102 back stages, the back depth set by the
// one-bit-per-stage square root and division pipes. Depends on rsi_pkg and rsi_if.
module ray_sphere_intersection_top #(
  parameter int unsigned FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rsi_in_if.sink    in_bus,
  rsi_out_if.source out_bus
);

  logic               f_valid, f_ready;
  logic               b_valid, b_ready;
  rsi_pkg::rsi_item_t f_item, b_item;

  // classify
  rsi_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  // decouple
  rsi_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_item  (b_item)
  );

  // solve
  rsi_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (b_valid),
    .item_ready (b_ready),
    .item       (b_item),
    .out_bus    (out_bus)
  );

endmodule

// File: hw/rtl/rsi_front.sv
// front end: forms half_b, a, c and the discriminant and classifies hit or miss
// depends on rsi_pkg and rsi_if
module rsi_front (
  input  logic              clk,
  input  logic              rst_n,
  rsi_in_if.sink            in_bus,
  output logic              item_valid,
  input  logic              item_ready,
  output rsi_pkg::rsi_item_t item
);

  localparam int unsigned DW  = rsi_pkg::DW;
  localparam int unsigned HBW = rsi_pkg::HBW;
  localparam int unsigned AW  = rsi_pkg::AW;

  logic [7:0] v_r;
  logic       fe;

  // the whole front pipe advances when its last stage is free or drained
  assign fe           = ~v_r[7] | item_ready;
  assign in_bus.ready = fe;
  assign item_valid   = v_r[7];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (fe) begin
      v_r <= {v_r[6:0], in_bus.valid};
    end
  end

  // stage 1: oc = origin - center
  logic signed [32:0] oc_nxt [3];
  logic signed [32:0] oc_r [3];
  logic signed [31:0] d_r [3];
  logic [30:0]        rad_r;

  always_comb begin
    oc_nxt[0] = 33'(in_bus.origin_x) - 33'(in_bus.center_x);
    oc_nxt[1] = 33'(in_bus.origin_y) - 33'(in_bus.center_y);
    oc_nxt[2] = 33'(in_bus.origin_z) - 33'(in_bus.center_z);
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      oc_r  <= oc_nxt;
      d_r[0] <= in_bus.dir_x;
      d_r[1] <= in_bus.dir_y;
      d_r[2] <= in_bus.dir_z;
      rad_r <= in_bus.sphere_radius;
    end
  end

  // stage 2: componentwise products
  logic signed [64:0] phb_nxt [3];
  logic signed [63:0] paa_full [3];
  logic signed [65:0] pcc_full [3];
  logic signed [64:0] phb_r [3];
  logic [62:0]        paa_r [3];
  logic [64:0]        pcc_r [3];
  logic [61:0]        rr_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      phb_nxt[i]  = oc_r[i] * d_r[i];
      paa_full[i] = d_r[i] * d_r[i];
      pcc_full[i] = oc_r[i] * oc_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      for (int i = 0; i < 3; i++) begin
        phb_r[i] <= phb_nxt[i];
        paa_r[i] <= paa_full[i][62:0];
        pcc_r[i] <= pcc_full[i][64:0];
      end
      rr_r <= 62'(rad_r) * 62'(rad_r);
    end
  end

  // stage 3: half_b, a, c
  logic signed [HBW-1:0] hb_nxt, hb3_r;
  logic [AW-1:0]         a_nxt, a3_r;
  logic signed [66:0]    c_nxt, c3_r;

  always_comb begin
    hb_nxt = '0;
    a_nxt  = '0;
    c_nxt  = -$signed({5'd0, rr_r});
    for (int i = 0; i < 3; i++) begin
      hb_nxt = hb_nxt + HBW'(phb_r[i]);
      a_nxt  = a_nxt + AW'(paa_r[i]);
      c_nxt  = c_nxt + $signed({2'd0, pcc_r[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      hb3_r <= hb_nxt;
      a3_r  <= a_nxt;
      c3_r  <= c_nxt;
    end
  end

  // stage 4: magnitudes for the wide squares
  logic signed [HBW-1:0] hb4_r;
  logic [65:0]           hbm4_r, cm4_r;
  logic                  cneg4_r, zero4_r;
  logic [AW-1:0]         a4_r;

  always_ff @(posedge clk) begin
    if (fe) begin
      hb4_r   <= hb3_r;
      hbm4_r  <= hb3_r[HBW-1] ? 66'(-hb3_r) : 66'(hb3_r);
      cm4_r   <= c3_r[66] ? 66'(-c3_r) : 66'(c3_r);
      cneg4_r <= c3_r[66];
      zero4_r <= (a3_r == '0);
      a4_r    <= a3_r;
    end
  end

  // stage 5: 32x32 partial products of half_b^2 and a*|c|
  logic [95:0]  hx, cx;
  logic [63:0]  pph_nxt [9];
  logic [63:0]  ppa_nxt [6];
  logic [63:0]  pph_r [9];
  logic [63:0]  ppa_r [6];
  logic signed [HBW-1:0] hb5_r;
  logic [AW-1:0] a5_r;
  logic          cneg5_r, zero5_r;

  always_comb begin
    hx = 96'(hbm4_r);
    cx = 96'(cm4_r);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pph_nxt[i*3+j] = 64'(hx[32*i +: 32]) * 64'(hx[32*j +: 32]);
      end
    end
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 3; j++) begin
        ppa_nxt[i*3+j] = 64'(a4_r[32*i +: 32]) * 64'(cx[32*j +: 32]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      pph_r   <= pph_nxt;
      ppa_r   <= ppa_nxt;
      hb5_r   <= hb4_r;
      a5_r    <= a4_r;
      cneg5_r <= cneg4_r;
      zero5_r <= zero4_r;
    end
  end

  // stage 6: row sums
  logic [DW-1:0] rowh_nxt [3];
  logic [DW-1:0] rowa_nxt [2];
  logic [DW-1:0] rowh_r [3];
  logic [DW-1:0] rowa_r [2];
  logic signed [HBW-1:0] hb6_r;
  logic [AW-1:0] a6_r;
  logic          cneg6_r, zero6_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rowh_nxt[i] = '0;
      for (int j = 0; j < 3; j++) begin
        rowh_nxt[i] = rowh_nxt[i] + (DW'(pph_r[i*3+j]) << (32*j));
      end
    end
    for (int i = 0; i < 2; i++) begin
      rowa_nxt[i] = '0;
      for (int j = 0; j < 3; j++) begin
        rowa_nxt[i] = rowa_nxt[i] + (DW'(ppa_r[i*3+j]) << (32*j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      rowh_r  <= rowh_nxt;
      rowa_r  <= rowa_nxt;
      hb6_r   <= hb5_r;
      a6_r    <= a5_r;
      cneg6_r <= cneg5_r;
      zero6_r <= zero5_r;
    end
  end

  // stage 7: half_b^2 and a*|c|
  logic [DW-1:0] hb2_r, ac_r;
  logic signed [HBW-1:0] hb7_r;
  logic [AW-1:0] a7_r;
  logic          cneg7_r, zero7_r;

  always_ff @(posedge clk) begin
    if (fe) begin
      hb2_r   <= rowh_r[0] + (rowh_r[1] << 32) + (rowh_r[2] << 64);
      ac_r    <= rowa_r[0] + (rowa_r[1] << 32);
      hb7_r   <= hb6_r;
      a7_r    <= a6_r;
      cneg7_r <= cneg6_r;
      zero7_r <= zero6_r;
    end
  end

  // stage 8: discriminant and classification
  logic [DW-1:0] disc_nxt;

  assign disc_nxt = cneg7_r ? (hb2_r + ac_r) : (hb2_r - ac_r);

  always_ff @(posedge clk) begin
    if (fe) begin
      item.hit  <= ~zero7_r & ~disc_nxt[DW-1];
      item.hb   <= hb7_r;
      item.a    <= a7_r;
      item.disc <= disc_nxt;
    end
  end

endmodule

// File: hw/rtl/rsi_queue.sv
// two-entry queue between the front end and the back end
// depends on rsi_pkg
module rsi_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  rsi_pkg::rsi_item_t wr_item,
  output logic               rd_valid,
  input  logic               rd_ready,
  output rsi_pkg::rsi_item_t rd_item
);

  rsi_pkg::rsi_item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = mem_r[rp_r];
  assign push     = wr_valid & wr_ready;
  assign pop      = rd_valid & rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: hw/rtl/rsi_back.sv
// back end: pipelined integer square root, nearer root, pipelined division, saturation
// depends on rsi_pkg and rsi_if
module rsi_back #(
  parameter int unsigned FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  output logic               item_ready,
  input  rsi_pkg::rsi_item_t item,
  rsi_out_if.source          out_bus
);

  localparam int unsigned DW  = rsi_pkg::DW;
  localparam int unsigned HBW = rsi_pkg::HBW;
  localparam int unsigned AW  = rsi_pkg::AW;
  localparam int unsigned RTW = rsi_pkg::RTW;
  localparam int unsigned RMW = rsi_pkg::RMW;
  localparam int unsigned QB  = rsi_pkg::QB;
  localparam int unsigned NW  = RTW + 2;          // magnitude of the numerator
  localparam int unsigned MW  = NW + FRAC_BITS;   // scaled numerator
  localparam int unsigned RW  = AW + 1;           // division remainder
  localparam int unsigned NB  = RTW + QB + 3;     // back pipe depth
  localparam logic [31:0] MissDist = ~((32'd1 << FRAC_BITS) - 32'd1);

  logic [NB-1:0] vb_r;
  logic          be;

  // stall-all pipe, free when the output register is empty or taken
  assign be         = ~vb_r[NB-1] | out_bus.ready;
  assign item_ready = be;
  assign out_bus.valid = vb_r[NB-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= '0;
    end else if (be) begin
      vb_r <= {vb_r[NB-2:0], item_valid};
    end
  end

  // square root: one result bit per stage
  logic [DW-1:0]         sn_r    [RTW];
  logic [RMW-1:0]        srem_r  [RTW];
  logic [RTW-1:0]        sroot_r [RTW];
  logic                  shit_r  [RTW];
  logic signed [HBW-1:0] shb_r   [RTW];
  logic [AW-1:0]         sa_r    [RTW];

  for (genvar k = 0; k < RTW; k++) begin : g_sqrt
    logic [DW-1:0]         n_in;
    logic [RMW-1:0]        rem_in, rem_sh, trial;
    logic [RTW-1:0]        root_in;
    logic                  hit_in, ge;
    logic signed [HBW-1:0] hb_in;
    logic [AW-1:0]         a_in;

    if (k == 0) begin : g_first
      assign n_in    = item.disc;
      assign rem_in  = '0;
      assign root_in = '0;
      assign hit_in  = item.hit;
      assign hb_in   = item.hb;
      assign a_in    = item.a;
    end else begin : g_next
      assign n_in    = sn_r[k-1];
      assign rem_in  = srem_r[k-1];
      assign root_in = sroot_r[k-1];
      assign hit_in  = shit_r[k-1];
      assign hb_in   = shb_r[k-1];
      assign a_in    = sa_r[k-1];
    end

    assign rem_sh = {rem_in[RMW-3:0], n_in[DW-1 -: 2]};
    assign trial  = RMW'({root_in, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (be) begin
        sn_r[k]    <= n_in << 2;
        srem_r[k]  <= ge ? (rem_sh - trial) : rem_sh;
        sroot_r[k] <= {root_in[RTW-2:0], ge};
        shit_r[k]  <= hit_in;
        shb_r[k]   <= hb_in;
        sa_r[k]    <= a_in;
      end
    end
  end

  // nearer root numerator -half_b - sqrt(disc), split into sign and magnitude
  logic signed [NW:0] num;
  logic [NW-1:0]      nmag_r;
  logic               nneg_r, nhit_r;
  logic [AW-1:0]      na_r;

  assign num = -(NW+1)'(shb_r[RTW-1]) - $signed((NW+1)'(sroot_r[RTW-1]));

  always_ff @(posedge clk) begin
    if (be) begin
      nneg_r <= num[NW];
      nmag_r <= num[NW] ? NW'(-num) : NW'(num);
      nhit_r <= shit_r[RTW-1];
      na_r   <= sa_r[RTW-1];
    end
  end

  // overflow check: quotient of at least 2^QB always saturates
  logic [MW-1:0] ms;
  logic [RW-1:0] r0;

  assign ms = MW'(nmag_r) << FRAC_BITS;
  assign r0 = RW'(ms >> QB);

  logic [RW-1:0] dr_r   [QB+1];
  logic [QB-1:0] dl_r   [QB+1];
  logic [QB-1:0] dq_r   [QB+1];
  logic          dbig_r [QB+1];
  logic          dneg_r [QB+1];
  logic          dhit_r [QB+1];
  logic [AW-1:0] da_r   [QB+1];

  always_ff @(posedge clk) begin
    if (be) begin
      dr_r[0]   <= r0;
      dl_r[0]   <= ms[QB-1:0];
      dq_r[0]   <= '0;
      dbig_r[0] <= (r0 >= RW'(na_r));
      dneg_r[0] <= nneg_r;
      dhit_r[0] <= nhit_r;
      da_r[0]   <= na_r;
    end
  end

  // restoring division: one quotient bit per stage
  for (genvar k = 1; k <= QB; k++) begin : g_div
    logic [RW-1:0] r_sh;
    logic          ge;

    assign r_sh = {dr_r[k-1][RW-2:0], dl_r[k-1][QB-1]};
    assign ge   = (r_sh >= RW'(da_r[k-1]));

    always_ff @(posedge clk) begin
      if (be) begin
        dr_r[k]   <= ge ? (r_sh - RW'(da_r[k-1])) : r_sh;
        dl_r[k]   <= dl_r[k-1] << 1;
        dq_r[k]   <= {dq_r[k-1][QB-2:0], ge};
        dbig_r[k] <= dbig_r[k-1];
        dneg_r[k] <= dneg_r[k-1];
        dhit_r[k] <= dhit_r[k-1];
        da_r[k]   <= da_r[k-1];
      end
    end
  end

  // saturation and miss value into the output register
  logic [QB-1:0] q;
  logic [31:0]   dist_nxt;

  assign q = dq_r[QB];

  always_comb begin
    if (!dhit_r[QB]) begin
      dist_nxt = MissDist;
    end else if (dneg_r[QB]) begin
      if (dbig_r[QB] || q > QB'(32'h8000_0000)) begin
        dist_nxt = 32'h8000_0000;
      end else begin
        dist_nxt = -q[31:0];
      end
    end else begin
      if (dbig_r[QB] || q > QB'(32'h7FFF_FFFF)) begin
        dist_nxt = 32'h7FFF_FFFF;
      end else begin
        dist_nxt = q[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      out_bus.hit      <= dhit_r[QB];
      out_bus.distance <= dist_nxt;
    end
  end

endmodule
